// File: rtl/iolh_pkg.sv
// Shared sizes, codes and item/result types for the IO latency histogram core.
// No dependencies; imported by every module of the block.
package iolh_pkg;

  localparam int unsigned INFLIGHT_ENTRIES = 64;
  localparam int unsigned STAT_ENTRIES     = 16;
  localparam int unsigned NUM_BUCKETS      = 32;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam int unsigned PEND_AW    = (INFLIGHT_ENTRIES > 1) ? $clog2(INFLIGHT_ENTRIES) : 1;
  localparam int unsigned STAT_AW    = $clog2(STAT_ENTRIES);
  localparam int unsigned HIST_DEPTH = STAT_ENTRIES * NUM_BUCKETS;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
  localparam int unsigned BKT_AW     = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned QUEUE_AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // ASCII 'R' marks a read request
  localparam logic [7:0] OP_READ_CHAR = 8'h52;

  typedef enum logic [1:0] {
    ACT_ISSUE    = 2'd0,
    ACT_COMPLETE = 2'd1,
    ACT_READ     = 2'd2,
    ACT_NONE     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_MISS  = 2'd1,
    ST_PFULL = 2'd2,
    ST_SFULL = 2'd3
  } status_e;

  // Request as held in the queue, already classified
  typedef struct packed {
    action_e     action;
    logic [31:0] device;
    logic [63:0] sector;
    logic        write_req;
    logic [31:0] byte_count;
    logic [63:0] timestamp;
    logic [3:0]  entry_index;
    logic [4:0]  bucket_index;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [4:0]  bucket;
    logic [63:0] latency;
    logic        entry_valid;
    logic [31:0] entry_device;
    logic        entry_write;
    logic [63:0] bin_count;
    logic [63:0] byte_total;
  } result_t;

endpackage

// File: rtl/iolh_front.sv
// Front end: takes requests, classifies them and queues them for the engine.
// Depends on iolh_pkg.
module iolh_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy_o,
  input  logic [1:0]     action_i,
  input  logic [31:0]    device_i,
  input  logic [63:0]    start_sector_i,
  input  logic [7:0]     op_char_i,
  input  logic [31:0]    byte_count_i,
  input  logic [63:0]    timestamp_i,
  input  logic [3:0]     entry_index_i,
  input  logic [4:0]     bucket_index_i,
  input  logic           pop_i,
  output logic           head_valid_o,
  output iolh_pkg::item_t head_o
);
  import iolh_pkg::*;

  item_t               queue_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]   count_q;
  item_t               item_in;
  logic                push, pop;

  // Classify the incoming request
  always_comb begin
    item_in.action       = action_e'(action_i);
    item_in.device       = device_i;
    item_in.sector       = start_sector_i;
    item_in.write_req    = (op_char_i != OP_READ_CHAR);
    item_in.byte_count   = byte_count_i;
    item_in.timestamp    = timestamp_i;
    item_in.entry_index  = entry_index_i;
    item_in.bucket_index = bucket_index_i;
  end

  assign busy_o       = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign push         = start && !busy_o;
  assign head_valid_o = (count_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = queue_q[rd_ptr_q];

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_in;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/iolh_back.sv
// Back end: sequencer that searches the in-flight and stats tables and
// updates the histogram memory. Depends on iolh_pkg.
module iolh_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  iolh_pkg::item_t   head_i,
  output logic              pop_o,
  output logic              done_o,
  output iolh_pkg::result_t result_o
);
  import iolh_pkg::*;

  localparam int unsigned HA_W = HIST_AW + 7;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DISP  = 9'b000000010,
    S_PSCAN = 9'b000000100,
    S_LAT   = 9'b000001000,
    S_LOG   = 9'b000010000,
    S_SSCAN = 9'b000100000,
    S_CLR   = 9'b001000000,
    S_HRD   = 9'b010000000,
    S_HUPD  = 9'b100000000
  } state_e;

  typedef struct packed {
    logic [31:0] device;
    logic [63:0] sector;
    logic [63:0] start;
    logic [31:0] bytes;
    logic        wr;
  } pend_t;

  function automatic logic [HIST_AW-1:0] hist_addr(input logic [STAT_AW-1:0] s,
                                                   input logic [6:0] b);
    logic [HA_W-1:0] a;
    a = HA_W'(s) * HA_W'(NUM_BUCKETS) + HA_W'(b);
    return a[HIST_AW-1:0];
  endfunction

  function automatic logic [2:0] msb8(input logic [7:0] v);
    logic [2:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      if (v[k]) r = 3'(k);
    end
    return r;
  endfunction

  state_e state_q, state_d;
  item_t  item_q;

  // in-flight table
  pend_t                       pend_mem [INFLIGHT_ENTRIES];
  pend_t                       pend_rd_q, ent_q, pend_wd;
  logic [INFLIGHT_ENTRIES-1:0] pend_valid_q;
  logic [PEND_AW-1:0]          scan_idx_q, chk_idx_q, free_idx_q, hit_idx_q, iss_idx;
  logic                        issued_all_q, chk_vld_q, free_q;
  logic                        pend_re, pend_we, pend_hit, pend_last, pend_free_now;
  logic                        scan_end, iss_ok;

  // latency and bucket
  logic [63:0] lat_q;
  logic [2:0]  byte_idx_q;
  logic        log_found_q;
  logic [5:0]  log_q;
  logic [7:0]  cur_byte;
  logic [6:0]  bkt_wide;

  // stats table
  logic [STAT_ENTRIES-1:0] stat_valid_q;
  logic [31:0]             stat_dev_q   [STAT_ENTRIES];
  logic                    stat_wr_q    [STAT_ENTRIES];
  logic [63:0]             stat_bytes_q [STAT_ENTRIES];
  logic [STAT_AW-1:0]      sidx_q, sfree_idx_q, s_alloc_idx;
  logic                    sfree_q, s_hit, s_free_now, s_last, s_alloc_ok;
  logic                    rd_valid, rd_bin;

  // histogram memory
  logic [63:0]        hist_mem [HIST_DEPTH];
  logic [63:0]        hist_rd_q, hist_wd, hist_inc, new_bytes;
  logic [HIST_AW-1:0] hist_addr_q;
  logic [BKT_AW-1:0]  clr_cnt_q;
  logic               hist_we, hist_re;

  result_t res_d, res_q;
  logic    res_load, done_q;

  // In-flight scan compare, one entry per cycle behind the memory read
  assign pend_hit = chk_vld_q && pend_valid_q[chk_idx_q]
                    && pend_rd_q.device == item_q.device && pend_rd_q.sector == item_q.sector;
  assign pend_last     = chk_vld_q && (chk_idx_q == PEND_AW'(INFLIGHT_ENTRIES-1));
  assign pend_free_now = chk_vld_q && !pend_valid_q[chk_idx_q];
  assign scan_end      = (state_q == S_PSCAN) && (pend_hit || pend_last);
  assign iss_ok        = pend_hit || free_q || pend_free_now;
  assign iss_idx       = pend_hit ? chk_idx_q : (free_q ? free_idx_q : chk_idx_q);
  assign pend_re       = (state_q == S_PSCAN) && !issued_all_q;
  assign pend_we       = scan_end && (item_q.action == ACT_ISSUE) && iss_ok;

  always_comb begin
    pend_wd.device = item_q.device;
    pend_wd.sector = item_q.sector;
    pend_wd.start  = item_q.timestamp;
    pend_wd.bytes  = item_q.byte_count;
    pend_wd.wr     = item_q.write_req;
  end

  // Log2 step: one byte of the latency per cycle, top byte first
  assign cur_byte = lat_q[{byte_idx_q, 3'b000} +: 8];
  assign bkt_wide = ({1'b0, log_q} >= 7'(NUM_BUCKETS)) ? 7'(NUM_BUCKETS-1) : {1'b0, log_q};

  // Stats scan compare
  assign s_hit = stat_valid_q[sidx_q] && stat_dev_q[sidx_q] == item_q.device
                 && stat_wr_q[sidx_q] == ent_q.wr;
  assign s_free_now  = !stat_valid_q[sidx_q];
  assign s_last      = (sidx_q == STAT_AW'(STAT_ENTRIES-1));
  assign s_alloc_ok  = sfree_q || s_free_now;
  assign s_alloc_idx = sfree_q ? sfree_idx_q : sidx_q;

  assign rd_valid = (32'(item_q.entry_index) < STAT_ENTRIES) && stat_valid_q[sidx_q];
  assign rd_bin   = (32'(item_q.bucket_index) < NUM_BUCKETS);

  assign hist_inc  = hist_rd_q + 64'd1;
  assign new_bytes = stat_bytes_q[sidx_q] + 64'(ent_q.bytes);
  assign hist_re   = (state_q == S_HRD);
  assign hist_we   = (state_q == S_CLR) ||
                     ((state_q == S_HUPD) && (item_q.action == ACT_COMPLETE));
  assign hist_wd   = (state_q == S_CLR) ? 64'd0 : hist_inc;
  assign pop_o     = (state_q == S_IDLE) && head_valid_i;

  // Next state and result
  always_comb begin
    state_d  = state_q;
    res_d    = '0;
    res_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (head_valid_i) state_d = S_DISP;
      end
      S_DISP: begin
        case (item_q.action)
          ACT_ISSUE, ACT_COMPLETE: state_d = S_PSCAN;
          ACT_READ: begin
            if (rd_valid && rd_bin) begin
              state_d = S_HRD;
            end else begin
              state_d            = S_IDLE;
              res_load           = 1'b1;
              res_d.entry_valid  = rd_valid;
              res_d.entry_device = rd_valid ? stat_dev_q[sidx_q] : '0;
              res_d.entry_write  = rd_valid && stat_wr_q[sidx_q];
              res_d.byte_total   = rd_valid ? stat_bytes_q[sidx_q] : '0;
            end
          end
          default: begin
            state_d  = S_IDLE;
            res_load = 1'b1;
          end
        endcase
      end
      S_PSCAN: begin
        if (scan_end) begin
          if (item_q.action == ACT_ISSUE) begin
            state_d      = S_IDLE;
            res_load     = 1'b1;
            res_d.status = iss_ok ? ST_DONE : ST_PFULL;
          end else if (pend_hit) begin
            state_d = S_LAT;
          end else begin
            state_d      = S_IDLE;
            res_load     = 1'b1;
            res_d.status = ST_MISS;
          end
        end
      end
      S_LAT: state_d = S_LOG;
      S_LOG: begin
        if (byte_idx_q == 3'd0) state_d = S_SSCAN;
      end
      S_SSCAN: begin
        if (s_hit) begin
          state_d = S_HRD;
        end else if (s_last) begin
          if (s_alloc_ok) begin
            state_d = S_CLR;
          end else begin
            state_d       = S_IDLE;
            res_load      = 1'b1;
            res_d.status  = ST_SFULL;
            res_d.bucket  = bkt_wide[4:0];
            res_d.latency = lat_q;
          end
        end
      end
      S_CLR: begin
        if (clr_cnt_q == BKT_AW'(NUM_BUCKETS-1)) state_d = S_HRD;
      end
      S_HRD: state_d = S_HUPD;
      S_HUPD: begin
        state_d            = S_IDLE;
        res_load           = 1'b1;
        res_d.entry_valid  = 1'b1;
        res_d.entry_device = stat_dev_q[sidx_q];
        res_d.entry_write  = stat_wr_q[sidx_q];
        if (item_q.action == ACT_COMPLETE) begin
          res_d.bucket     = bkt_wide[4:0];
          res_d.latency    = lat_q;
          res_d.bin_count  = hist_inc;
          res_d.byte_total = new_bytes;
        end else begin
          res_d.bin_count  = hist_rd_q;
          res_d.byte_total = stat_bytes_q[sidx_q];
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pend_valid_q <= '0;
      stat_valid_q <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= res_load;
      if (pend_we) pend_valid_q[iss_idx] <= 1'b1;
      if (state_q == S_SSCAN && !s_hit && s_last) begin
        if (s_alloc_ok) stat_valid_q[s_alloc_idx] <= 1'b1;
        else            pend_valid_q[hit_idx_q]   <= 1'b0;
      end
      if (state_q == S_HUPD && item_q.action == ACT_COMPLETE) begin
        pend_valid_q[hit_idx_q] <= 1'b0;
      end
    end
  end

  // In-flight memory
  always_ff @(posedge clk_i) begin
    if (pend_we) pend_mem[iss_idx] <= pend_wd;
    if (pend_re) pend_rd_q <= pend_mem[scan_idx_q];
  end

  // Histogram memory
  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hist_addr_q] <= hist_wd;
    if (hist_re) hist_rd_q <= hist_mem[hist_addr_q];
  end

  // Sequencer datapath
  always_ff @(posedge clk_i) begin
    if (res_load) res_q <= res_d;
    case (state_q)
      S_IDLE: begin
        if (head_valid_i) begin
          item_q <= head_i;
          sidx_q <= STAT_AW'(head_i.entry_index);
        end
      end
      S_DISP: begin
        scan_idx_q   <= '0;
        issued_all_q <= 1'b0;
        chk_vld_q    <= 1'b0;
        free_q       <= 1'b0;
        hist_addr_q  <= hist_addr(sidx_q, 7'(item_q.bucket_index));
      end
      S_PSCAN: begin
        chk_vld_q <= !issued_all_q;
        chk_idx_q <= scan_idx_q;
        if (!issued_all_q) begin
          if (scan_idx_q == PEND_AW'(INFLIGHT_ENTRIES-1)) issued_all_q <= 1'b1;
          else                                            scan_idx_q   <= scan_idx_q + 1'b1;
        end
        if (pend_free_now && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= chk_idx_q;
        end
        if (pend_hit) begin
          ent_q     <= pend_rd_q;
          hit_idx_q <= chk_idx_q;
        end
      end
      S_LAT: begin
        lat_q       <= item_q.timestamp - ent_q.start;
        byte_idx_q  <= 3'd7;
        log_found_q <= 1'b0;
        log_q       <= '0;
      end
      S_LOG: begin
        if (!log_found_q && cur_byte != 8'd0) begin
          log_found_q <= 1'b1;
          log_q       <= {byte_idx_q, msb8(cur_byte)};
        end
        byte_idx_q <= byte_idx_q - 1'b1;
        if (byte_idx_q == 3'd0) begin
          sidx_q  <= '0;
          sfree_q <= 1'b0;
        end
      end
      S_SSCAN: begin
        if (s_hit) begin
          hist_addr_q <= hist_addr(sidx_q, bkt_wide);
        end else begin
          if (s_free_now && !sfree_q) begin
            sfree_q     <= 1'b1;
            sfree_idx_q <= sidx_q;
          end
          if (!s_last) begin
            sidx_q <= sidx_q + 1'b1;
          end else if (s_alloc_ok) begin
            // new stats entry, histogram row cleared next
            sidx_q                    <= s_alloc_idx;
            stat_dev_q[s_alloc_idx]   <= item_q.device;
            stat_wr_q[s_alloc_idx]    <= ent_q.wr;
            stat_bytes_q[s_alloc_idx] <= '0;
            hist_addr_q               <= hist_addr(s_alloc_idx, 7'd0);
            clr_cnt_q                 <= '0;
          end
        end
      end
      S_CLR: begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == BKT_AW'(NUM_BUCKETS-1)) hist_addr_q <= hist_addr(sidx_q, bkt_wide);
        else                                     hist_addr_q <= hist_addr_q + 1'b1;
      end
      S_HUPD: begin
        if (item_q.action == ACT_COMPLETE) stat_bytes_q[sidx_q] <= new_bytes;
      end
      default: ;
    endcase
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// File: rtl/io_latency_log2_histogram_core.sv
// Top level of the IO latency log2 histogram core.
// Depends on iolh_pkg, iolh_front and iolh_back.
//
//  channel   handshake          payload
//  request   start / busy       action_i device_i start_sector_i op_char_i byte_count_i
//                               timestamp_i entry_index_i bucket_index_i
//  result    done_o (1 cycle)   status_o bucket_o latency_o entry_valid_o entry_device_o
//                               entry_write_o bin_count_o byte_total_o
//
// Requests are taken into a 2-deep queue; busy is high only while it is full.
// Issue time is set by the in-flight memory scan (one entry per cycle through its
// single read port). Completion adds the log2 step and a stats table scan, plus a
// clear of the histogram row (one word a cycle) when a stats entry is allocated.
// Read: stats lookup, then a histogram read if entry and bucket are valid.
// Reset clears all valid bits at once; no clearing pass. done_o cannot be stalled.
module io_latency_log2_histogram_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [31:0] device_i,
  input  logic [63:0] start_sector_i,
  input  logic [7:0]  op_char_i,
  input  logic [31:0] byte_count_i,
  input  logic [63:0] timestamp_i,
  input  logic [3:0]  entry_index_i,
  input  logic [4:0]  bucket_index_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [4:0]  bucket_o,
  output logic [63:0] latency_o,
  output logic        entry_valid_o,
  output logic [31:0] entry_device_o,
  output logic        entry_write_o,
  output logic [63:0] bin_count_o,
  output logic [63:0] byte_total_o
);
  import iolh_pkg::*;

  item_t   head;
  logic    head_valid, pop;
  result_t result;

  iolh_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy_o        (busy),
    .action_i      (action_i),
    .device_i      (device_i),
    .start_sector_i(start_sector_i),
    .op_char_i     (op_char_i),
    .byte_count_i  (byte_count_i),
    .timestamp_i   (timestamp_i),
    .entry_index_i (entry_index_i),
    .bucket_index_i(bucket_index_i),
    .pop_i         (pop),
    .head_valid_o  (head_valid),
    .head_o        (head)
  );

  iolh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .done_o      (done_o),
    .result_o    (result)
  );

  assign status_o       = result.status;
  assign bucket_o       = result.bucket;
  assign latency_o      = result.latency;
  assign entry_valid_o  = result.entry_valid;
  assign entry_device_o = result.entry_device;
  assign entry_write_o  = result.entry_write;
  assign bin_count_o    = result.bin_count;
  assign byte_total_o   = result.byte_total;

endmodule

// File: rtl/iolh_checker.sv
// Port-level checks for the IO latency histogram core, bound to the top level.
// Depends on iolh_pkg and io_latency_log2_histogram_core.
module iolh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [4:0]  bucket_o,
  input logic [63:0] latency_o,
  input logic        entry_valid_o,
  input logic [31:0] entry_device_o,
  input logic        entry_write_o,
  input logic [63:0] bin_count_o,
  input logic [63:0] byte_total_o
);
  import iolh_pkg::*;

  // done_o is never high twice in a row; the engine returns to idle between results
  a_done_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("results on consecutive cycles");

  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_MISS |-> bucket_o == '0 && latency_o == '0 && !entry_valid_o)
    else $error("miss result carries data");

  a_invalid_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !entry_valid_o |-> entry_device_o == '0 && !entry_write_o
                                 && bin_count_o == '0 && byte_total_o == '0)
    else $error("entry fields set without a valid entry");

  a_full_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_PFULL || status_o == ST_SFULL) |-> !entry_valid_o)
    else $error("table-full result reports an entry");

endmodule

bind io_latency_log2_histogram_core iolh_checker u_iolh_checker (.*);

// File: test/tb_top.sv
// Self-checking testbench for io_latency_log2_histogram_core.
// Depends on iolh_pkg and the core RTL; predicts every result from its own table model.
`timescale 1ns / 1ps

module tb_top;
  import iolh_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;

  typedef struct {
    logic [1:0]  action;
    logic [31:0] device;
    logic [63:0] sector;
    logic [7:0]  op_char;
    logic [31:0] byte_count;
    logic [63:0] timestamp;
    logic [3:0]  entry_index;
    logic [4:0]  bucket_index;
  } io_req_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  action_i;
  logic [31:0] device_i;
  logic [63:0] start_sector_i;
  logic [7:0]  op_char_i;
  logic [31:0] byte_count_i;
  logic [63:0] timestamp_i;
  logic [3:0]  entry_index_i;
  logic [4:0]  bucket_index_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic [4:0]  bucket_o;
  logic [63:0] latency_o;
  logic        entry_valid_o;
  logic [31:0] entry_device_o;
  logic        entry_write_o;
  logic [63:0] bin_count_o;
  logic [63:0] byte_total_o;

  io_latency_log2_histogram_core DUT (.*);

  // Predictor state: in-flight table and stats table
  logic        inf_valid [INFLIGHT_ENTRIES];
  logic [31:0] inf_dev   [INFLIGHT_ENTRIES];
  logic [63:0] inf_sec   [INFLIGHT_ENTRIES];
  logic [63:0] inf_start [INFLIGHT_ENTRIES];
  logic [31:0] inf_bytes [INFLIGHT_ENTRIES];
  logic        inf_wr    [INFLIGHT_ENTRIES];
  logic        dev_valid [STAT_ENTRIES];
  logic [31:0] dev_id    [STAT_ENTRIES];
  logic        dev_wr    [STAT_ENTRIES];
  logic [63:0] dev_bytes [STAT_ENTRIES];
  logic [63:0] dev_hist  [STAT_ENTRIES][NUM_BUCKETS];

  io_req_t     pending_reqs[$];
  result_t     expected_results[$];
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_seen = 0;
  int unsigned n_done_compl = 0;
  int unsigned n_sfull = 0;
  int unsigned n_pfull = 0;
  int unsigned cycle_cnt = 0;
  bit          calm = 0;

  function automatic int find_inflight(logic [31:0] d, logic [63:0] s);
    for (int i = 0; i < INFLIGHT_ENTRIES; i++)
      if (inf_valid[i] && inf_dev[i] == d && inf_sec[i] == s) return i;
    return -1;
  endfunction

  // Apply one request to the model, return what the core should report
  function automatic result_t predict_event(io_req_t r);
    result_t     res;
    int          idx;
    int          sidx;
    logic [63:0] lat;
    int unsigned b;
    res = '0;
    res.status = ST_DONE;
    case (action_e'(r.action))
      ACT_ISSUE: begin
        idx = find_inflight(r.device, r.sector);
        if (idx < 0)
          for (int k = 0; k < INFLIGHT_ENTRIES; k++)
            if (!inf_valid[k]) begin
              idx = k;
              break;
            end
        if (idx < 0) begin
          res.status = ST_PFULL;
        end else begin
          inf_valid[idx] = 1'b1;
          inf_dev[idx]   = r.device;
          inf_sec[idx]   = r.sector;
          inf_start[idx] = r.timestamp;
          inf_bytes[idx] = r.byte_count;
          inf_wr[idx]    = (r.op_char != OP_READ_CHAR);
        end
      end
      ACT_COMPLETE: begin
        idx = find_inflight(r.device, r.sector);
        if (idx < 0) begin
          res.status = ST_MISS;
        end else begin
          lat = r.timestamp - inf_start[idx];
          b = 0;
          for (int j = 1; j < 64; j++) if (lat[j]) b = j;
          if (b >= NUM_BUCKETS) b = NUM_BUCKETS - 1;
          res.bucket  = b[4:0];
          res.latency = lat;
          sidx = -1;
          for (int k = 0; k < STAT_ENTRIES; k++)
            if (dev_valid[k] && dev_id[k] == r.device && dev_wr[k] == inf_wr[idx]) begin
              sidx = k;
              break;
            end
          if (sidx < 0)
            for (int k = 0; k < STAT_ENTRIES; k++)
              if (!dev_valid[k]) begin
                sidx = k;
                dev_valid[k] = 1'b1;
                dev_id[k]    = r.device;
                dev_wr[k]    = inf_wr[idx];
                dev_bytes[k] = '0;
                for (int j = 0; j < NUM_BUCKETS; j++) dev_hist[k][j] = '0;
                break;
              end
          inf_valid[idx] = 1'b0;
          if (sidx < 0) begin
            res.status = ST_SFULL;
          end else begin
            dev_hist[sidx][b] += 64'd1;
            dev_bytes[sidx]   += {32'd0, inf_bytes[idx]};
            res.entry_valid  = 1'b1;
            res.entry_device = r.device;
            res.entry_write  = inf_wr[idx];
            res.bin_count    = dev_hist[sidx][b];
            res.byte_total   = dev_bytes[sidx];
          end
        end
      end
      ACT_READ: begin
        if (r.entry_index < STAT_ENTRIES && dev_valid[r.entry_index]) begin
          res.entry_valid  = 1'b1;
          res.entry_device = dev_id[r.entry_index];
          res.entry_write  = dev_wr[r.entry_index];
          if (r.bucket_index < NUM_BUCKETS)
            res.bin_count = dev_hist[r.entry_index][r.bucket_index];
          res.byte_total = dev_bytes[r.entry_index];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic io_req_t rand_req(logic [1:0] act);
    io_req_t r;
    r.action       = act;
    r.device       = $urandom;
    r.sector       = {$urandom, $urandom};
    r.op_char      = 8'($urandom);
    r.byte_count   = $urandom;
    r.timestamp    = {$urandom, $urandom};
    r.entry_index  = 4'($urandom);
    r.bucket_index = 5'($urandom);
    return r;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: presents the next queued request, idles at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start          <= 1'b0;
      action_i       <= '0;
      device_i       <= '0;
      start_sector_i <= '0;
      op_char_i      <= '0;
      byte_count_i   <= '0;
      timestamp_i    <= '0;
      entry_index_i  <= '0;
      bucket_index_i <= '0;
      for (int i = 0; i < INFLIGHT_ENTRIES; i++) begin
        inf_valid[i] = 1'b0; inf_dev[i] = '0; inf_sec[i] = '0;
        inf_start[i] = '0; inf_bytes[i] = '0; inf_wr[i] = 1'b0;
      end
      for (int k = 0; k < STAT_ENTRIES; k++) begin
        dev_valid[k] = 1'b0; dev_id[k] = '0; dev_wr[k] = 1'b0; dev_bytes[k] = '0;
        for (int j = 0; j < NUM_BUCKETS; j++) dev_hist[k][j] = '0;
      end
    end else begin
      if (start && !busy) begin
        expected_results.push_back(predict_event(pending_reqs.pop_front()));
        n_sent++;
      end
      if ((start && busy) ||
          (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 37))) begin
        start          <= 1'b1;
        action_i       <= pending_reqs[0].action;
        device_i       <= pending_reqs[0].device;
        start_sector_i <= pending_reqs[0].sector;
        op_char_i      <= pending_reqs[0].op_char;
        byte_count_i   <= pending_reqs[0].byte_count;
        timestamp_i    <= pending_reqs[0].timestamp;
        entry_index_i  <= pending_reqs[0].entry_index;
        bucket_index_i <= pending_reqs[0].bucket_index;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compares each result strobe with the oldest prediction
  always @(posedge clk_i) begin
    result_t e;
    cycle_cnt++;
    if (rst_ni && done_o) begin
      n_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, status_o);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (e.status == ST_DONE && e.entry_valid && e.latency != 0) n_done_compl++;
        if (e.status == ST_SFULL) n_sfull++;
        if (e.status == ST_PFULL) n_pfull++;
        if ({e.status, e.bucket, e.latency, e.entry_valid, e.entry_device, e.entry_write,
             e.bin_count, e.byte_total} !==
            {status_o, bucket_o, latency_o, entry_valid_o, entry_device_o, entry_write_o,
             bin_count_o, byte_total_o}) begin
          $display("%0t: mismatch exp st=%0d b=%0d lat=%h v=%b dev=%h w=%b cnt=%h bytes=%h",
                   $time, e.status, e.bucket, e.latency, e.entry_valid, e.entry_device,
                   e.entry_write, e.bin_count, e.byte_total);
          $display("%0t:          act st=%0d b=%0d lat=%h v=%b dev=%h w=%b cnt=%h bytes=%h",
                   $time, status_o, bucket_o, latency_o, entry_valid_o, entry_device_o,
                   entry_write_o, bin_count_o, byte_total_o);
          errors++;
        end
      end
    end
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    io_req_t     r;
    int unsigned pick;
    rst_ni = 1'b0;

    // Directed: extremes, overwrite, miss, zero and huge latency, reads, unused action
    r = rand_req(ACT_ISSUE); r.device = '1; r.sector = '1; r.op_char = OP_READ_CHAR;
    r.byte_count = '1; r.timestamp = '1; pending_reqs.push_back(r);
    r.timestamp = 64'd5; pending_reqs.push_back(r);                   // overwrite in place
    r.action = ACT_COMPLETE; r.timestamp = 64'd5; pending_reqs.push_back(r); // completes at its issue timestamp
    pending_reqs.push_back(r);                                          // now a miss
    r = rand_req(ACT_ISSUE); r.device = '0; r.sector = '0; r.op_char = 8'hFF;
    r.byte_count = '1; r.timestamp = 64'd10; pending_reqs.push_back(r);
    r.action = ACT_COMPLETE; r.timestamp = 64'd9; pending_reqs.push_back(r); // wraps, top bucket
    r = rand_req(ACT_ISSUE); r.device = '0; r.sector = '0; r.op_char = 8'h00;
    r.timestamp = 64'd0; pending_reqs.push_back(r);
    r.action = ACT_COMPLETE; r.timestamp = 64'd1; pending_reqs.push_back(r); // bucket 0, same entry
    for (int k = 0; k < 3; k++) begin
      r = rand_req(ACT_READ); r.entry_index = 4'(k); r.bucket_index = 5'(NUM_BUCKETS - 1);
      pending_reqs.push_back(r);
      r.bucket_index = 5'd0; pending_reqs.push_back(r);
    end
    r = rand_req(ACT_READ); r.entry_index = 4'hF; pending_reqs.push_back(r);
    r = rand_req(ACT_NONE); pending_reqs.push_back(r);
    r = rand_req(ACT_COMPLETE); pending_reqs.push_back(r);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Random: paired issue/complete on a few devices, table-filling bursts, noise
    for (int n = 0; n < 600; n++) begin
      if (n == 300) begin
        wait (pending_reqs.size() == 0);
        calm = 1;
      end
      if (n == 380) begin
        // let the back-to-back stretch drain before idling resumes
        wait (pending_reqs.size() == 0);
        calm = 0;
      end
      pick = $urandom_range(99);
      if (n >= 150 && n < 220) begin
        // Flood issues to fill the in-flight table
        r = rand_req(ACT_ISSUE);
        r.device = $urandom_range(3);
      end else if (n >= 400 && n < 470) begin
        // Many distinct devices to fill the stats table
        r = rand_req(ACT_ISSUE); r.sector = 64'(n); r.timestamp = {$urandom_range(3), 32'd0};
        pending_reqs.push_back(r);
        r.action = ACT_COMPLETE; r.timestamp += {$urandom, $urandom} >> $urandom_range(63);
        n++;
      end else if (pick < 80) begin
        r = rand_req(ACT_ISSUE);
        r.device = $urandom_range(5);
        r.sector = 64'($urandom_range(7));
        if ($urandom_range(1)) r.op_char = OP_READ_CHAR;
        pending_reqs.push_back(r);
        r.action = ACT_COMPLETE;
        r.timestamp += {$urandom, $urandom} >> $urandom_range(63);
        n++;
      end else if (pick < 92) begin
        r = rand_req(ACT_READ);
        r.bucket_index = 5'($urandom_range(NUM_BUCKETS - 1) |
                            ($urandom_range(9) == 0 ? 32'h10 : 32'h0));
      end else if (pick < 96) begin
        r = rand_req(ACT_COMPLETE);
      end else begin
        r = rand_req(ACT_NONE);
      end
      pending_reqs.push_back(r);
    end
    wait (pending_reqs.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (INFLIGHT_ENTRIES + STAT_ENTRIES + NUM_BUCKETS + 40) @(posedge clk_i);

    $display("Sent %0d requests, checked %0d results: %0d table-full issues,",
             n_sent, n_seen, n_pfull);
    $display("%0d stats-full completions, %0d nonzero-latency updates.", n_sfull, n_done_compl);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/iolh_pkg.sv
rtl/iolh_front.sv
rtl/iolh_back.sv
rtl/io_latency_log2_histogram_core.sv
rtl/iolh_checker.sv
test/tb_top.sv
